FILE: sv/safsk_pkg.sv
// shared constants, types and sine table for the same afsk alert tone generator
package safsk_pkg;

    localparam int HEADER_BYTES    = 256;
    localparam int SAMPLES_PER_BIT = 85;
    localparam int SAMPLE_RATE     = 44100;
    localparam int SINE_INDEX_BITS = 10;

    localparam int ADDR_W = $clog2(HEADER_BYTES);
    localparam int BP_W   = $clog2(HEADER_BYTES + 1);
    localparam int BSC_W  = $clog2(SAMPLES_PER_BIT + 1);
    localparam int REM_W  = 21;
    localparam int ATT_W  = 21;

    localparam int QUARTER = (1 << SINE_INDEX_BITS) >> 2;
    localparam int KW      = SINE_INDEX_BITS - 1;
    localparam int RW      = SINE_INDEX_BITS - 2;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hAB;
    localparam logic [7:0] EOM_CHAR      = 8'h4E;
    localparam int         EOM_BYTES     = 20;
    localparam int         EOM_PREAMBLE  = 16;
    localparam int         MAX_ATTENTION = 25;

    localparam logic [3:0] LAST_SEGMENT      = 4'd13;
    localparam logic [3:0] ATTENTION_SEGMENT = 4'd6;
    localparam logic [3:0] LAST_HEADER_SEG   = 4'd4;

    // request commands
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_HEADER_LENGTH  = 3'd0;
    localparam logic [2:0] REG_ATTENTION_SECS = 3'd1;
    localparam logic [2:0] REG_MARK_STEP      = 3'd2;
    localparam logic [2:0] REG_SPACE_STEP     = 3'd3;
    localparam logic [2:0] REG_ATT_FIRST      = 3'd4;
    localparam logic [2:0] REG_ATT_SECOND     = 3'd5;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [3:0]         segment;
        logic               message_end;
        logic               finished;
    } result_t;

    typedef logic [14:0] qsine_tab_t [0:QUARTER];

    // restoring long division, only used while building the table
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // first-quadrant sine magnitude, odd taylor series to x^9 in q30
    function automatic logic [14:0] quarter_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned mag;
        longint unsigned dv;
        x    = (longint'(k) * TWO_PI_Q30) >> SINE_INDEX_BITS;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        for (int i = 1; i <= 4; i++)
        begin
            case (i)
                1:       dv = 6;
                2:       dv = 20;
                3:       dv = 42;
                default: dv = 72;
            endcase
            term = div_u64((term * x2) >> 30, dv);
            if (i[0])
                neg = neg + term;
            else
                pos = pos + term;
        end
        mag = (pos > neg) ? pos - neg : 64'd0;
        mag = (mag * 32767 + (64'd1 << 29)) >> 30;
        if (mag > 32767)
            mag = 32767;
        return mag[14:0];
    endfunction

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t tab;
        for (int k = 0; k <= QUARTER; k++)
        begin
            tab[k] = quarter_sine(k);
        end
        return tab;
    endfunction

    localparam qsine_tab_t QSINE = build_qsine();

    // q1.15 sine of a 16-bit phase, quadrant mirrored from the table
    function automatic logic signed [15:0] sine_q15(input logic [15:0] phase);
        logic [SINE_INDEX_BITS-1:0] idx;
        logic [1:0]                 q;
        logic [RW-1:0]              r;
        logic [KW-1:0]              k;
        logic signed [15:0]         m;
        idx = phase[15 -: SINE_INDEX_BITS];
        q   = idx[SINE_INDEX_BITS-1 -: 2];
        r   = idx[RW-1:0];
        k   = q[0] ? KW'(QUARTER) - {1'b0, r} : {1'b0, r};
        m   = signed'({1'b0, QSINE[k]});
        return q[1] ? -m : m;
    endfunction

    function automatic logic [BP_W-1:0] eff_header_length(input logic [8:0] hl);
        int unsigned h;
        h = hl;
        if (h == 0)
            h = 1;
        if (h > HEADER_BYTES)
            h = HEADER_BYTES;
        return BP_W'(h);
    endfunction

    function automatic logic [REM_W-1:0] segment_length(input logic [3:0] seg,
                                                        input logic [8:0] hl,
                                                        input logic [4:0] att);
        int unsigned a;
        int unsigned len;
        a = att;
        if (a == 0)
            a = 1;
        if (a > MAX_ATTENTION)
            a = MAX_ATTENTION;
        if (seg[0])
            len = SAMPLE_RATE;
        else if (seg <= LAST_HEADER_SEG)
            len = 32'(eff_header_length(hl)) * 8 * SAMPLES_PER_BIT;
        else if (seg == ATTENTION_SEGMENT)
            len = a * SAMPLE_RATE;
        else
            len = EOM_BYTES * 8 * SAMPLES_PER_BIT;
        return REM_W'(len);
    endfunction

endpackage

FILE: sv/safsk_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module safsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

FILE: sv/safsk_out_queue.sv
// small result queue between the sample pipeline and the output channel
module safsk_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  safsk_pkg::result_t push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output safsk_pkg::result_t out_data,
    output logic [2:0]        level
);

    localparam int Q_DEPTH = 4;

    safsk_pkg::result_t entry_reg [0:Q_DEPTH-1];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'b00, push} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: sv/same_afsk_alert_tone_generator_unit.sv
// same afsk alert tone generator: sequencer, header byte ram, sine pipeline
// pipeline: a sample request is registered in stage one and stage two, then pushed into the result queue
// throughput: one request per cycle; ready drops only when the result queue
//   and the two pipeline stages together hold four results
// reset: control and configuration registers reset at once, no clearing pass;
//   the header byte ram holds nothing defined until written
module same_afsk_alert_tone_generator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [7:0]         byte_index,
    input  logic [7:0]         byte_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample,
    output logic [3:0]         segment,
    output logic               message_end,
    output logic               finished
);

    typedef enum logic [2:0] {
        KIND_SILENCE,
        KIND_ATTENTION,
        KIND_HEADER,
        KIND_EOM,
        KIND_FINISHED
    } kind_t;

    // configuration
    logic [8:0]  header_length_reg;
    logic [4:0]  attention_seconds_reg;
    logic [15:0] mark_step_reg;
    logic [15:0] space_step_reg;
    logic [15:0] att_first_reg;
    logic [15:0] att_second_reg;

    // sequencer state
    logic [3:0]                   seg_reg, seg_next;
    logic [safsk_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [safsk_pkg::BSC_W-1:0]  bsc_reg, bsc_next;
    logic [2:0]                   bit_idx_reg, bit_idx_next;
    logic [safsk_pkg::BP_W-1:0]   byte_pos_reg, byte_pos_next;
    logic [safsk_pkg::ATT_W-1:0]  att_cnt_reg, att_cnt_next;
    logic                         done_reg, done_next;

    // stage one
    logic                        s1_valid_reg, s1_valid_next;
    kind_t                       s1_kind_reg, s1_kind_next;
    logic [3:0]                  s1_seg_reg, s1_seg_next;
    logic                        s1_end_reg, s1_end_next;
    logic [2:0]                  s1_bit_reg, s1_bit_next;
    logic [safsk_pkg::BSC_W-1:0] s1_bsc_reg, s1_bsc_next;
    logic                        s1_eom_n_reg, s1_eom_n_next;
    logic [15:0]                 s1_att_reg, s1_att_next;

    // stage two
    logic        s2_valid_reg;
    kind_t       s2_kind_reg;
    logic [3:0]  s2_seg_reg;
    logic        s2_end_reg;
    logic [15:0] s2_phase_a_reg;
    logic [15:0] s2_phase_b_reg;

    logic                          in_fire;
    logic                          ram_we;
    logic                          ram_re;
    logic [safsk_pkg::ADDR_W-1:0]  ram_waddr;
    logic [safsk_pkg::ADDR_W-1:0]  ram_raddr;
    logic [7:0]                    ram_rdata;

    logic [safsk_pkg::REM_W-1:0]   rem_dec;
    logic [safsk_pkg::BSC_W-1:0]   bsc_inc;
    logic [safsk_pkg::BP_W-1:0]    byte_pos_inc;
    logic [safsk_pkg::BP_W-1:0]    burst_len;

    logic [7:0]  cur_byte;
    logic [15:0] afsk_step;
    logic [15:0] mul_a_op1;
    logic [15:0] mul_a_op2;
    logic [31:0] prod_a;
    logic [31:0] prod_b;

    logic signed [15:0] sin_a;
    logic signed [15:0] sin_b;
    logic signed [16:0] sin_sum;
    logic signed [16:0] sin_avg;
    safsk_pkg::result_t push_data;
    safsk_pkg::result_t head;
    logic [2:0]         q_level;
    logic [3:0]         in_flight;

    assign in_flight = {1'b0, q_level} + {3'b000, s1_valid_reg} + {3'b000, s2_valid_reg};
    assign in_ready  = (in_flight < 4'd4);
    assign in_fire   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_length_reg     <= 9'd64;
            attention_seconds_reg <= 5'd8;
            mark_step_reg         <= 16'd3096;
            space_step_reg        <= 16'd2322;
            att_first_reg         <= 16'd1268;
            att_second_reg        <= 16'd1427;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                safsk_pkg::REG_HEADER_LENGTH:  header_length_reg     <= cfg_data[8:0];
                safsk_pkg::REG_ATTENTION_SECS: attention_seconds_reg <= cfg_data[4:0];
                safsk_pkg::REG_MARK_STEP:      mark_step_reg         <= cfg_data;
                safsk_pkg::REG_SPACE_STEP:     space_step_reg        <= cfg_data;
                safsk_pkg::REG_ATT_FIRST:      att_first_reg         <= cfg_data;
                safsk_pkg::REG_ATT_SECOND:     att_second_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: advances on each accepted sample request, issues the header byte read
    always_comb
    begin
        seg_next      = seg_reg;
        rem_next      = rem_reg;
        bsc_next      = bsc_reg;
        bit_idx_next  = bit_idx_reg;
        byte_pos_next = byte_pos_reg;
        att_cnt_next  = att_cnt_reg;
        done_next     = done_reg;

        s1_valid_next = 1'b0;
        s1_kind_next  = KIND_SILENCE;
        s1_seg_next   = seg_reg;
        s1_end_next   = 1'b0;
        s1_bit_next   = bit_idx_reg;
        s1_bsc_next   = bsc_reg;
        s1_eom_n_next = (byte_pos_reg >= safsk_pkg::BP_W'(safsk_pkg::EOM_PREAMBLE));
        s1_att_next   = att_cnt_reg[15:0];

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = safsk_pkg::ADDR_W'(byte_index);
        ram_raddr = byte_pos_reg[safsk_pkg::ADDR_W-1:0];

        rem_dec      = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
        bsc_inc      = bsc_reg + 1'b1;
        byte_pos_inc = byte_pos_reg + 1'b1;
        burst_len    = (seg_reg <= safsk_pkg::LAST_HEADER_SEG)
                       ? safsk_pkg::eff_header_length(header_length_reg)
                       : safsk_pkg::BP_W'(safsk_pkg::EOM_BYTES);

        if (in_fire)
        begin
            case (command)
                safsk_pkg::CMD_WRITE:
                begin
                    ram_we = (32'(byte_index) < safsk_pkg::HEADER_BYTES);
                end
                safsk_pkg::CMD_RESTART:
                begin
                    seg_next      = '0;
                    bsc_next      = '0;
                    bit_idx_next  = '0;
                    byte_pos_next = '0;
                    att_cnt_next  = '0;
                    done_next     = 1'b0;
                    rem_next      = safsk_pkg::segment_length(4'd0, header_length_reg,
                                                              attention_seconds_reg);
                end
                safsk_pkg::CMD_SAMPLE:
                begin
                    s1_valid_next = 1'b1;
                    ram_re        = 1'b1;
                    if (done_reg)
                    begin
                        s1_kind_next = KIND_FINISHED;
                        s1_seg_next  = safsk_pkg::LAST_SEGMENT;
                    end
                    else
                    begin
                        if (seg_reg[0])
                        begin
                            s1_kind_next = KIND_SILENCE;
                        end
                        else if (seg_reg == safsk_pkg::ATTENTION_SEGMENT)
                        begin
                            s1_kind_next = KIND_ATTENTION;
                            att_cnt_next = att_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            s1_kind_next = (seg_reg <= safsk_pkg::LAST_HEADER_SEG)
                                           ? KIND_HEADER : KIND_EOM;
                            if (bsc_inc == safsk_pkg::BSC_W'(safsk_pkg::SAMPLES_PER_BIT))
                            begin
                                bsc_next = '0;
                                if (bit_idx_reg == 3'd7)
                                begin
                                    bit_idx_next  = '0;
                                    byte_pos_next = (byte_pos_inc >= burst_len)
                                                    ? '0 : byte_pos_inc;
                                end
                                else
                                begin
                                    bit_idx_next = bit_idx_reg + 3'd1;
                                end
                            end
                            else
                            begin
                                bsc_next = bsc_inc;
                            end
                        end

                        rem_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            if (seg_reg >= safsk_pkg::LAST_SEGMENT)
                            begin
                                done_next   = 1'b1;
                                s1_end_next = 1'b1;
                            end
                            else
                            begin
                                seg_next      = seg_reg + 4'd1;
                                rem_next      = safsk_pkg::segment_length(seg_reg + 4'd1,
                                                    header_length_reg, attention_seconds_reg);
                                bsc_next      = '0;
                                bit_idx_next  = '0;
                                byte_pos_next = '0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        // header length change before the first sample reloads the first burst
        if (cfg_we && cfg_index == safsk_pkg::REG_HEADER_LENGTH && seg_reg == 4'd0
            && !done_reg && bsc_reg == '0 && bit_idx_reg == '0 && byte_pos_reg == '0)
        begin
            rem_next = safsk_pkg::segment_length(4'd0, cfg_data[8:0], attention_seconds_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg      <= '0;
            rem_reg      <= safsk_pkg::segment_length(4'd0, 9'd64, 5'd8);
            bsc_reg      <= '0;
            bit_idx_reg  <= '0;
            byte_pos_reg <= '0;
            att_cnt_reg  <= '0;
            done_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg      <= seg_next;
            rem_reg      <= rem_next;
            bsc_reg      <= bsc_next;
            bit_idx_reg  <= bit_idx_next;
            byte_pos_reg <= byte_pos_next;
            att_cnt_reg  <= att_cnt_next;
            done_reg     <= done_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    safsk_ram #(
        .WIDTH (8),
        .DEPTH (safsk_pkg::HEADER_BYTES)
    ) u_header_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // stage one: bit selection and phase products
    always_comb
    begin
        cur_byte = (s1_kind_reg == KIND_HEADER) ? ram_rdata
                 : (s1_eom_n_reg ? safsk_pkg::EOM_CHAR : safsk_pkg::PREAMBLE_BYTE);
        afsk_step = cur_byte[s1_bit_reg] ? mark_step_reg : space_step_reg;
        if (s1_kind_reg == KIND_ATTENTION)
        begin
            mul_a_op1 = s1_att_reg;
            mul_a_op2 = att_first_reg;
        end
        else
        begin
            mul_a_op1 = 16'(s1_bsc_reg);
            mul_a_op2 = afsk_step;
        end
        prod_a = mul_a_op1 * mul_a_op2;
        prod_b = s1_att_reg * att_second_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg    <= s1_kind_next;
        s1_seg_reg     <= s1_seg_next;
        s1_end_reg     <= s1_end_next;
        s1_bit_reg     <= s1_bit_next;
        s1_bsc_reg     <= s1_bsc_next;
        s1_eom_n_reg   <= s1_eom_n_next;
        s1_att_reg     <= s1_att_next;
        s2_kind_reg    <= s1_kind_reg;
        s2_seg_reg     <= s1_seg_reg;
        s2_end_reg     <= s1_end_reg;
        s2_phase_a_reg <= prod_a[15:0];
        s2_phase_b_reg <= prod_b[15:0];
    end

    // stage two: sine lookup and tone mix
    always_comb
    begin
        sin_a   = safsk_pkg::sine_q15(s2_phase_a_reg);
        sin_b   = safsk_pkg::sine_q15(s2_phase_b_reg);
        sin_sum = 17'(sin_a) + 17'(sin_b);
        // halve, truncating toward zero
        sin_avg = (sin_sum + {16'b0, sin_sum[16]}) >>> 1;

        push_data.segment     = s2_seg_reg;
        push_data.message_end = s2_end_reg;
        push_data.finished    = 1'b0;
        case (s2_kind_reg)
            KIND_ATTENTION: push_data.sample = sin_avg[15:0];
            KIND_HEADER,
            KIND_EOM:       push_data.sample = sin_a;
            KIND_FINISHED:
            begin
                push_data.sample   = '0;
                push_data.finished = 1'b1;
            end
            default:        push_data.sample = '0;
        endcase
    end

    safsk_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (push_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (head),
        .level     (q_level)
    );

    assign sample      = head.sample;
    assign segment     = head.segment;
    assign message_end = head.message_end;
    assign finished    = head.finished;

endmodule
